// ----- hw/rtl/gapped_kmer_histogram_counter_top_macros.svh -----
// Assertion macros shared by the gapped k-mer histogram counter RTL.
`ifndef GAPPED_KMER_HISTOGRAM_COUNTER_TOP_MACROS_SVH
`define GAPPED_KMER_HISTOGRAM_COUNTER_TOP_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define GKHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset.
`define GKHC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GKHC_ASSERT(lbl, prop, msg)
`define GKHC_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/gkhc_pkg.sv -----
// Types, constants and opcodes of the gapped k-mer histogram counter.
`timescale 1ns / 1ps
package gkhc_pkg;

  localparam int unsigned MAX_OLIGO  = 8;
  localparam int unsigned MAX_GAP    = 25;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned WIN_DEPTH  = MAX_OLIGO + MAX_GAP;
  localparam int unsigned KEY_BITS   = 2 * MAX_OLIGO;
  localparam int unsigned WIN_IDX_BITS = $clog2(WIN_DEPTH);
  localparam int unsigned FILL_BITS  = $clog2(WIN_DEPTH + 1);

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] CFG_OLIGO  = 2'd0;
  localparam logic [1:0] CFG_PREFIX = 2'd1;
  localparam logic [1:0] CFG_GAP    = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  base;
    logic [15:0] read_key;
  } in_word_t;

  typedef struct packed {
    logic [23:0] count_value;
    logic        saturated;
  } out_word_t;

  // Table access issued by the key stage.
  typedef struct packed {
    logic                valid;
    logic                inc;
    logic                rd;
    logic [KEY_BITS-1:0] addr;
  } req_t;

  // Table status seen by the handshake logic.
  typedef struct packed {
    logic clearing;
    logic s2_valid;
    logic s2_rd;
  } tbl_stat_t;

endpackage

// ----- hw/rtl/gkhc_window.sv -----
// Base window shift register, region fill count and gapped key extraction.
`timescale 1ns / 1ps
module gkhc_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            start_i,
  input  logic [1:0]                      base_i,
  input  logic [3:0]                      oligo_len_i,
  input  logic [2:0]                      prefix_len_i,
  input  logic [4:0]                      gap_len_i,
  output logic [gkhc_pkg::KEY_BITS-1:0]   key_o,
  output logic                            hit_o
);

  logic [1:0] win_q [gkhc_pkg::WIN_DEPTH];
  logic [gkhc_pkg::FILL_BITS-1:0] fill_q;

  logic [3:0] olig_eff;
  logic [3:0] pre_eff;
  logic [4:0] gap_eff;
  logic [3:0] suf_len;
  logic [gkhc_pkg::FILL_BITS-1:0] span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gkhc_pkg::WIN_DEPTH; i++) begin
        win_q[i] <= 2'd0;
      end
      fill_q <= '0;
    end else if (start_i) begin
      for (int i = 0; i < gkhc_pkg::WIN_DEPTH; i++) begin
        win_q[i] <= 2'd0;
      end
      fill_q <= '0;
    end else if (push_i) begin
      win_q[0] <= base_i;
      for (int i = 1; i < gkhc_pkg::WIN_DEPTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
      if (fill_q != gkhc_pkg::FILL_BITS'(gkhc_pkg::WIN_DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Clamp the configuration to the supported ranges.
  always_comb begin
    if (oligo_len_i == 4'd0) begin
      olig_eff = 4'd1;
    end else if (oligo_len_i > 4'(gkhc_pkg::MAX_OLIGO)) begin
      olig_eff = 4'(gkhc_pkg::MAX_OLIGO);
    end else begin
      olig_eff = oligo_len_i;
    end
    pre_eff = ({1'b0, prefix_len_i} > olig_eff) ? olig_eff : {1'b0, prefix_len_i};
    gap_eff = (gap_len_i > 5'(gkhc_pkg::MAX_GAP)) ? 5'(gkhc_pkg::MAX_GAP) : gap_len_i;
    suf_len = olig_eff - pre_eff;
    span    = gkhc_pkg::FILL_BITS'(olig_eff) + gkhc_pkg::FILL_BITS'(gap_eff);
  end

  // Key digit d (two bits, digit 0 least significant) comes from the suffix
  // taps below the suffix length and from the gap-shifted prefix taps above it.
  always_comb begin
    logic [gkhc_pkg::WIN_IDX_BITS-1:0] sel;
    key_o = '0;
    for (int d = 0; d < gkhc_pkg::MAX_OLIGO; d++) begin
      sel = gkhc_pkg::WIN_IDX_BITS'(gap_eff) + gkhc_pkg::WIN_IDX_BITS'(d);
      if (4'(d) < suf_len) begin
        key_o[2*d +: 2] = win_q[d];
      end else if (4'(d) < olig_eff) begin
        key_o[2*d +: 2] = win_q[sel];
      end
    end
  end

  assign hit_o = (fill_q >= span);

endmodule

// ----- hw/rtl/gkhc_table.sv -----
// Histogram memory with read-modify-write, forwarding and clearing sweep.
`timescale 1ns / 1ps
`include "gapped_kmer_histogram_counter_top_macros.svh"
module gkhc_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gkhc_pkg::req_t       req_i,
  input  logic                 clear_i,
  output gkhc_pkg::tbl_stat_t  stat_o,
  output logic                 res_valid_o,
  output gkhc_pkg::out_word_t  res_word_o
);

  localparam logic [gkhc_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [gkhc_pkg::COUNT_BITS-1:0] mem_q [2**gkhc_pkg::KEY_BITS];
  logic [gkhc_pkg::COUNT_BITS-1:0] rdata_q;

  gkhc_pkg::req_t s2_q;
  logic                            clearing_q;
  logic [gkhc_pkg::KEY_BITS-1:0]   clr_cnt_q;
  logic                            fwd_valid_q;
  logic [gkhc_pkg::KEY_BITS-1:0]   fwd_addr_q;
  logic [gkhc_pkg::COUNT_BITS-1:0] fwd_data_q;

  logic [gkhc_pkg::COUNT_BITS-1:0] cur_count;
  logic [gkhc_pkg::COUNT_BITS-1:0] inc_count;
  logic                            wr_en;
  logic [gkhc_pkg::KEY_BITS-1:0]   wr_addr;
  logic [gkhc_pkg::COUNT_BITS-1:0] wr_data;

  // The entry written in the previous cycle was read before that write landed.
  assign cur_count = (fwd_valid_q && (fwd_addr_q == s2_q.addr)) ? fwd_data_q : rdata_q;
  assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

  always_comb begin
    if (clearing_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else begin
      wr_en   = s2_q.valid && s2_q.inc;
      wr_addr = s2_q.addr;
      wr_data = inc_count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.valid) begin
      rdata_q <= mem_q[req_i.addr];
    end
    fwd_addr_q <= s2_q.addr;
    fwd_data_q <= inc_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q        <= '0;
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      s2_q        <= req_i;
      fwd_valid_q <= s2_q.valid && s2_q.inc;
      if (clear_i) begin
        clearing_q <= 1'b1;
        clr_cnt_q  <= '0;
      end else if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.clearing = clearing_q;
  assign stat_o.s2_valid = s2_q.valid;
  assign stat_o.s2_rd    = s2_q.valid && s2_q.rd;

  assign res_valid_o            = s2_q.valid && s2_q.rd;
  assign res_word_o.count_value = cur_count;
  assign res_word_o.saturated   = (cur_count == COUNT_MAX);

  `GKHC_NEVER(a_no_req_in_sweep, clearing_q && req_i.valid, "table access during clearing sweep")
  `GKHC_NEVER(a_rd_inc_excl, s2_q.valid && s2_q.rd && s2_q.inc, "read and increment at once")
  `GKHC_ASSERT(a_clear_when_empty, clear_i |-> !s2_q.valid && !req_i.valid, "clear with access in flight")

endmodule

// ----- hw/rtl/gapped_kmer_histogram_counter_top.sv -----
// Top level of the gapped k-mer histogram counter.
`timescale 1ns / 1ps
`include "gapped_kmer_histogram_counter_top_macros.svh"
// Gapped k-mer histogram counter. Each input word carries an opcode: push a
// base into the window, start a new region, clear the histogram, or read one
// count. A push is taken every cycle unless a clearing sweep stalls the input;
// the key of the gapped k-mer that ends at the pushed base is formed in the
// cycle after, the histogram entry is read from the synchronous memory, and the
// saturating increment is written in the next cycle, with the last written
// count forwarded so that back-to-back hits on the same key count correctly. A
// read's word passes the key stage and the table's read register into the
// output register, from which it can be taken; a read is held off while an
// earlier read's word is still in the output register or in flight, so reads
// never overlap. Clearing the table walks all 65536 entries, one per cycle,
// while the input is stalled; the same sweep runs right after reset. A clear
// waits until pending histogram updates have been written. Configuration
// registers (oligo length, prefix length, gap length) are written through a
// plain write port and must only change while the block is idle.
module gapped_kmer_histogram_counter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gkhc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gkhc_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [4:0]          cfg_wdata_i
);

  logic [3:0] oligo_len_q;
  logic [2:0] prefix_len_q;
  logic [4:0] gap_len_q;

  // Key stage: registers the accepted push or read while the
  // window produces the key.
  logic        s1_valid_q;
  logic        s1_rd_q;
  logic [15:0] s1_key_q;

  logic                       out_valid_q;
  gkhc_pkg::out_word_t        out_word_q;

  logic                               in_acc;
  logic                               is_read;
  logic                               is_clear;
  logic                               read_block;
  logic                               clear_block;
  logic [gkhc_pkg::KEY_BITS-1:0]      win_key;
  logic                               win_hit;
  gkhc_pkg::req_t                     req;
  gkhc_pkg::tbl_stat_t                stat;
  logic                               res_valid;
  gkhc_pkg::out_word_t                res_word;

  assign is_read  = (in_word_i.opcode == gkhc_pkg::OP_READ);
  assign is_clear = (in_word_i.opcode == gkhc_pkg::OP_CLEAR);

  // A read only enters when the output register is sure to be free on its
  // arrival; a clear only enters once no update is left in the pipeline.
  assign read_block  = out_valid_q || (s1_valid_q && s1_rd_q) || stat.s2_rd;
  assign clear_block = s1_valid_q || stat.s2_valid;
  assign in_stall_o  = stat.clearing
                     || (in_valid_i && is_read && read_block)
                     || (in_valid_i && is_clear && clear_block);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oligo_len_q  <= 4'd6;
      prefix_len_q <= 3'd3;
      gap_len_q    <= 5'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gkhc_pkg::CFG_OLIGO:  oligo_len_q  <= cfg_wdata_i[3:0];
        gkhc_pkg::CFG_PREFIX: prefix_len_q <= cfg_wdata_i[2:0];
        gkhc_pkg::CFG_GAP:    gap_len_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_rd_q    <= 1'b0;
    end else begin
      s1_valid_q <= in_acc && (is_read || (in_word_i.opcode == gkhc_pkg::OP_PUSH));
      s1_rd_q    <= is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_key_q <= in_word_i.read_key;
  end

  gkhc_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_acc && (in_word_i.opcode == gkhc_pkg::OP_PUSH)),
    .start_i      (in_acc && (in_word_i.opcode == gkhc_pkg::OP_START)),
    .base_i       (in_word_i.base),
    .oligo_len_i  (oligo_len_q),
    .prefix_len_i (prefix_len_q),
    .gap_len_i    (gap_len_q),
    .key_o        (win_key),
    .hit_o        (win_hit)
  );

  // A push whose window does not yet span the gapped k-mer issues nothing.
  assign req.valid = s1_valid_q && (s1_rd_q || win_hit);
  assign req.inc   = !s1_rd_q;
  assign req.rd    = s1_rd_q;
  assign req.addr  = s1_rd_q ? s1_key_q : win_key;

  gkhc_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .clear_i     (in_acc && is_clear),
    .stat_o      (stat),
    .res_valid_o (res_valid),
    .res_word_o  (res_word)
  );

  // Output register: the result word waits here while the pipeline goes on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `GKHC_NEVER(a_out_overrun, res_valid && out_valid_q, "read word arrived at a full output register")
  `GKHC_ASSERT(a_read_latency, (s1_valid_q && s1_rd_q) |=> res_valid, "read word not produced in time")
  `GKHC_ASSERT(a_clear_starts, (in_acc && is_clear) |=> stat.clearing, "clear did not start the sweep")

endmodule
